[rtl/discounted_regret_matching_update_core_defines.svh]
// Assertion helpers shared by the core.
`ifndef DISCOUNTED_REGRET_MATCHING_UPDATE_CORE_DEFINES_SVH
`define DISCOUNTED_REGRET_MATCHING_UPDATE_CORE_DEFINES_SVH

// same-cycle implication, checked on clk, off during rst
`define DRMU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("drmu check failed");

// next-cycle implication
`define DRMU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("drmu check failed");

`endif

[rtl/drmu_pkg.sv]
package drmu_pkg;

  localparam int HAND_W      = 11;
  localparam int REGRET_W    = 32;
  localparam int CUM_W       = 32;
  localparam int PROB_W      = 17;
  localparam int WEIGHT_W    = 16;
  localparam int COUNT_W     = 4;
  localparam int FIELD_LANES = 8;
  localparam int SUM_W       = 35;
  localparam int REM_W       = SUM_W + 1;
  localparam int CFG_IDX_W   = 3;

  // pipeline depth after the input stage
  localparam int FRONT_STAGES = 4;
  localparam int SUM_STAGES   = 2;
  localparam int DIV_STEPS    = PROB_W;
  localparam int FIN_STAGES   = 2;
  localparam int NSTG = FRONT_STAGES + SUM_STAGES + DIV_STEPS + FIN_STAGES;

  typedef enum logic [1:0] {
    REQ_UPDATE  = 2'd0,
    REQ_CURRENT = 2'd1,
    REQ_AVERAGE = 2'd2,
    REQ_UNKNOWN = 2'd3
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTION_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POSITIVE_WEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NEGATIVE_WEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_WEIGHT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_DECAY   = 3'd4;

  typedef struct packed {
    logic [WEIGHT_W-1:0] pos_w;
    logic [WEIGHT_W-1:0] neg_w;
    logic [WEIGHT_W-1:0] avg_w;
    logic [WEIGHT_W-1:0] avg_decay;
  } wt_t;

  // floor(65536 / n) for n = 1..8
  function automatic logic [PROB_W-1:0] uniform_prob(input logic [COUNT_W-1:0] n);
    logic [PROB_W-1:0] p;
    unique case (n)
      4'd1:    p = 17'd65536;
      4'd2:    p = 17'd32768;
      4'd3:    p = 17'd21845;
      4'd4:    p = 17'd16384;
      4'd5:    p = 17'd13107;
      4'd6:    p = 17'd10922;
      4'd7:    p = 17'd9362;
      4'd8:    p = 17'd8192;
      default: p = 17'd0;
    endcase
    return p;
  endfunction

endpackage

[rtl/drmu_if.sv]
interface drmu_req_if;
  import drmu_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [HAND_W-1:0]   hand;
  logic signed [REGRET_W-1:0] regret_a0;
  logic signed [REGRET_W-1:0] regret_a1;
  logic signed [REGRET_W-1:0] regret_a2;
  logic signed [REGRET_W-1:0] regret_a3;
  logic signed [REGRET_W-1:0] regret_a4;
  logic signed [REGRET_W-1:0] regret_a5;
  logic signed [REGRET_W-1:0] regret_a6;
  logic signed [REGRET_W-1:0] regret_a7;

  modport source (output valid, req_type, hand, regret_a0, regret_a1, regret_a2,
                  regret_a3, regret_a4, regret_a5, regret_a6, regret_a7,
                  input ready);
  modport sink (input valid, req_type, hand, regret_a0, regret_a1, regret_a2,
                regret_a3, regret_a4, regret_a5, regret_a6, regret_a7,
                output ready);
endinterface

interface drmu_rsp_if;
  import drmu_pkg::*;
  logic              valid;
  logic              ready;
  logic [HAND_W-1:0] hand_out;
  logic [PROB_W-1:0] prob_a0;
  logic [PROB_W-1:0] prob_a1;
  logic [PROB_W-1:0] prob_a2;
  logic [PROB_W-1:0] prob_a3;
  logic [PROB_W-1:0] prob_a4;
  logic [PROB_W-1:0] prob_a5;
  logic [PROB_W-1:0] prob_a6;
  logic [PROB_W-1:0] prob_a7;

  modport source (output valid, hand_out, prob_a0, prob_a1, prob_a2, prob_a3,
                  prob_a4, prob_a5, prob_a6, prob_a7, input ready);
  modport sink (input valid, hand_out, prob_a0, prob_a1, prob_a2, prob_a3,
                prob_a4, prob_a5, prob_a6, prob_a7, output ready);
endinterface

[rtl/discounted_regret_matching_update_core.sv]
// Discounted regret-matching core. Takes one request beat per clock unless
// stalled: an update folds a hand's regrets into the stored row, rescales
// each by the positive or negative weight, forms the regret-matching strategy
// and folds it into the cumulative strategy; reads return the current or the
// average strategy; an unknown request returns zeros. Every request yields one
// result beat. A request to a row that an earlier update still has in flight
// waits in the input stage until that update has written its row; otherwise,
// while the output is not stalled, the rate is one beat per cycle, with a
// pipelined 17-stage divider per lane and one read and one write port on
// each lane RAM. After reset a clearing pass writes zero to all MAX_HANDS
// rows, one row per cycle, during which no request is taken; configuration
// writes are taken at any time.
`include "discounted_regret_matching_update_core_defines.svh"

module discounted_regret_matching_update_core
  import drmu_pkg::*;
#(
  parameter int MAX_HANDS   = 2048,
  parameter int MAX_ACTIONS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_data,
  drmu_req_if.sink             req,
  drmu_rsp_if.source           rsp
);

  localparam int ROW_W   = (MAX_HANDS > 1) ? $clog2(MAX_HANDS) : 1;
  localparam int REQ3    = 3;
  localparam int REQ_FIN = FRONT_STAGES + SUM_STAGES + DIV_STEPS;

  // configuration
  logic [COUNT_W-1:0] action_count;
  wt_t                wt;
  logic [COUNT_W-1:0] n_eff;
  logic [MAX_ACTIONS-1:0] lane_on;
  logic [PROB_W-1:0]  uniform;

  always_ff @(posedge clk) begin
    if (rst) begin
      action_count <= 4'd2;
      wt.pos_w     <= 16'd32768;
      wt.neg_w     <= 16'd32768;
      wt.avg_w     <= 16'd32768;
      wt.avg_decay <= 16'd65535;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACTION_COUNT:    action_count <= cfg_data[COUNT_W-1:0];
        CFG_POSITIVE_WEIGHT: wt.pos_w     <= cfg_data;
        CFG_NEGATIVE_WEIGHT: wt.neg_w     <= cfg_data;
        CFG_AVERAGE_WEIGHT:  wt.avg_w     <= cfg_data;
        CFG_AVERAGE_DECAY:   wt.avg_decay <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (action_count == '0) begin
      n_eff = 4'd1;
    end else if (action_count > COUNT_W'(MAX_ACTIONS)) begin
      n_eff = COUNT_W'(MAX_ACTIONS);
    end else begin
      n_eff = action_count;
    end
    for (int l = 0; l < MAX_ACTIONS; l++) begin
      lane_on[l] = (COUNT_W'(l) < n_eff);
    end
    uniform = uniform_prob(n_eff);
  end

  // clearing pass
  logic             clr_active;
  logic [ROW_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      if (clr_addr == ROW_W'(MAX_HANDS - 1)) begin
        clr_active <= 1'b0;
        clr_addr   <= '0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // input stage
  logic signed [REGRET_W-1:0] req_regret [FIELD_LANES];
  assign req_regret[0] = req.regret_a0;
  assign req_regret[1] = req.regret_a1;
  assign req_regret[2] = req.regret_a2;
  assign req_regret[3] = req.regret_a3;
  assign req_regret[4] = req.regret_a4;
  assign req_regret[5] = req.regret_a5;
  assign req_regret[6] = req.regret_a6;
  assign req_regret[7] = req.regret_a7;

  logic                       p0_valid;
  req_t                       p0_req;
  logic [HAND_W-1:0]          p0_hand;
  logic [ROW_W-1:0]           p0_row;
  logic signed [REGRET_W-1:0] p0_regret [FIELD_LANES];
  logic [23:0]                row_red;
  logic                       in_ready, p0_move, hazard, adv;

  // hand modulo MAX_HANDS by conditional subtraction of shifted multiples
  always_comb begin
    row_red = 24'(req.hand);
    for (int k = HAND_W - 1; k >= 0; k--) begin
      if (row_red >= (24'(MAX_HANDS) << k)) begin
        row_red = row_red - (24'(MAX_HANDS) << k);
      end
    end
  end

  // pipeline control
  logic              ctl_valid [1:NSTG];
  req_t              ctl_req   [1:NSTG];
  logic [HAND_W-1:0] ctl_hand  [1:NSTG];
  logic [ROW_W-1:0]  ctl_row   [1:NSTG];

  logic              out_valid;
  logic [HAND_W-1:0] out_hand;
  logic [PROB_W-1:0] out_prob [FIELD_LANES];

  assign adv = !out_valid || rsp.ready;

  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= NSTG; k++) begin
      if (ctl_valid[k] && ctl_req[k] == REQ_UPDATE && ctl_row[k] == p0_row) begin
        hazard = 1'b1;
      end
    end
  end

  assign p0_move  = p0_valid && adv && !hazard;
  assign in_ready = !clr_active && (!p0_valid || p0_move);
  assign req.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p0_valid <= 1'b0;
    end else if (req.valid && in_ready) begin
      p0_valid <= 1'b1;
    end else if (p0_move) begin
      p0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && in_ready) begin
      p0_req    <= req_t'(req.req_type);
      p0_hand   <= req.hand;
      p0_row    <= row_red[ROW_W-1:0];
      p0_regret <= req_regret;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= NSTG; k++) begin
        ctl_valid[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      ctl_valid[1] <= p0_move;
      for (int k = 2; k <= NSTG; k++) begin
        ctl_valid[k] <= ctl_valid[k-1];
      end
      out_valid <= ctl_valid[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_req[1]  <= p0_req;
      ctl_hand[1] <= p0_hand;
      ctl_row[1]  <= p0_row;
      for (int k = 2; k <= NSTG; k++) begin
        ctl_req[k]  <= ctl_req[k-1];
        ctl_hand[k] <= ctl_hand[k-1];
        ctl_row[k]  <= ctl_row[k-1];
      end
    end
  end

  // lanes
  logic [CUM_W-1:0]           val4  [MAX_ACTIONS];
  logic signed [REGRET_W-1:0] newr4 [MAX_ACTIONS];
  logic [CUM_W-1:0]           cdsh4 [MAX_ACTIONS];
  logic [SUM_W-1:0]           sum6;
  logic [PROB_W-1:0]          prob_fin [MAX_ACTIONS];
  logic signed [REGRET_W-1:0] newr_fin [MAX_ACTIONS];
  logic [CUM_W-1:0]           cavg_fin [MAX_ACTIONS];
  logic                       wb_we;
  logic [ROW_W-1:0]           waddr;

  assign wb_we = adv && ctl_valid[NSTG] && ctl_req[NSTG] == REQ_UPDATE;
  assign waddr = clr_active ? clr_addr : ctl_row[NSTG];

  for (genvar l = 0; l < MAX_ACTIONS; l++) begin : g_lane
    logic signed [REGRET_W-1:0] old_reg;
    logic [CUM_W-1:0]           old_cum;
    logic                       we;

    assign we = clr_active || (wb_we && lane_on[l]);

    drmu_ram #(.WIDTH(REGRET_W), .DEPTH(MAX_HANDS), .AW(ROW_W)) u_regret_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (clr_active ? '0 : newr_fin[l]),
      .re    (p0_move),
      .raddr (p0_row),
      .rdata (old_reg)
    );

    drmu_ram #(.WIDTH(CUM_W), .DEPTH(MAX_HANDS), .AW(ROW_W)) u_average_ram (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (clr_active ? '0 : cavg_fin[l]),
      .re    (p0_move),
      .raddr (p0_row),
      .rdata (old_cum)
    );

    drmu_lane_front u_front (
      .clk       (clk),
      .adv       (adv),
      .regret_in (p0_regret[l]),
      .old_reg   (old_reg),
      .old_cum   (old_cum),
      .wt        (wt),
      .req3      (ctl_req[REQ3]),
      .lane_on   (lane_on[l]),
      .val4      (val4[l]),
      .newr4     (newr4[l]),
      .cdsh4     (cdsh4[l])
    );

    drmu_lane_back u_back (
      .clk      (clk),
      .adv      (adv),
      .val4     (val4[l]),
      .newr4    (newr4[l]),
      .cdsh4    (cdsh4[l]),
      .sum6     (sum6),
      .req_fin  (ctl_req[REQ_FIN]),
      .lane_on  (lane_on[l]),
      .uniform  (uniform),
      .avg_w    (wt.avg_w),
      .prob_out (prob_fin[l]),
      .newr_out (newr_fin[l]),
      .cavg_out (cavg_fin[l])
    );
  end

  drmu_sum #(.LANES(MAX_ACTIONS)) u_sum (
    .clk (clk),
    .adv (adv),
    .val (val4),
    .sum (sum6)
  );

  // output register
  always_ff @(posedge clk) begin
    if (adv) begin
      out_hand <= ctl_hand[NSTG];
      for (int l = 0; l < FIELD_LANES; l++) begin
        out_prob[l] <= (l < MAX_ACTIONS) ? prob_fin[l % MAX_ACTIONS] : '0;
      end
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.hand_out = out_hand;
  assign rsp.prob_a0  = out_prob[0];
  assign rsp.prob_a1  = out_prob[1];
  assign rsp.prob_a2  = out_prob[2];
  assign rsp.prob_a3  = out_prob[3];
  assign rsp.prob_a4  = out_prob[4];
  assign rsp.prob_a5  = out_prob[5];
  assign rsp.prob_a6  = out_prob[6];
  assign rsp.prob_a7  = out_prob[7];

  `DRMU_ASSERT_NOW(a_no_accept_while_clearing, clr_active, !req.ready)
  `DRMU_ASSERT_NOW(a_no_writeback_while_clearing, clr_active, !wb_we && !ctl_valid[NSTG])
  `DRMU_ASSERT_NOW(a_clear_covers_all_rows, $fell(clr_active),
                   $past(clr_addr) == ROW_W'(MAX_HANDS - 1))
  `DRMU_ASSERT_NEXT(a_read_sees_no_pending_update, p0_move && adv,
                    !(ctl_valid[1] && ctl_valid[NSTG] && ctl_req[NSTG] == REQ_UPDATE
                      && ctl_row[NSTG] == ctl_row[1] && $past(wb_we)))

endmodule

[rtl/drmu_ram.sv]
module drmu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/drmu_lane_front.sv]
module drmu_lane_front
  import drmu_pkg::*;
(
  input  logic                       clk,
  input  logic                       adv,
  input  logic signed [REGRET_W-1:0] regret_in,
  input  logic signed [REGRET_W-1:0] old_reg,
  input  logic [CUM_W-1:0]           old_cum,
  input  wt_t                        wt,
  input  req_t                       req3,
  input  logic                       lane_on,
  output logic [CUM_W-1:0]           val4,
  output logic signed [REGRET_W-1:0] newr4,
  output logic [CUM_W-1:0]           cdsh4
);

  logic signed [REGRET_W-1:0] r1_rg;
  logic signed [REGRET_W:0]   acc;
  logic signed [REGRET_W-1:0] sat;

  logic signed [REGRET_W-1:0] s2, old2;
  logic [CUM_W-1:0]           cum2;
  logic [WEIGHT_W-1:0]        w;
  logic signed [48:0]         prod;
  logic [47:0]                cd;

  logic signed [48:0]         prod3;
  logic signed [REGRET_W-1:0] old3;
  logic [CUM_W-1:0]           cum3, cdsh3;
  logic signed [REGRET_W-1:0] newr;
  logic [CUM_W-1:0]           val;

  always_comb begin
    acc = $signed({old_reg[REGRET_W-1], old_reg}) + $signed({r1_rg[REGRET_W-1], r1_rg});
    if (acc[REGRET_W] != acc[REGRET_W-1]) begin
      sat = acc[REGRET_W] ? {1'b1, {(REGRET_W-1){1'b0}}} : {1'b0, {(REGRET_W-1){1'b1}}};
    end else begin
      sat = acc[REGRET_W-1:0];
    end
  end

  always_comb begin
    w    = (s2 > 0) ? wt.pos_w : wt.neg_w;
    prod = 49'(s2) * 49'($signed({1'b0, w}));
    cd   = 48'(cum2) * 48'(wt.avg_decay);
  end

  // arithmetic shift of the product is the floor of the Q0.16 scaling
  always_comb begin
    newr = prod3[47:16];
    val  = '0;
    if (lane_on) begin
      unique case (req3)
        REQ_UPDATE:  val = newr[REGRET_W-1] ? '0 : CUM_W'(newr);
        REQ_CURRENT: val = old3[REGRET_W-1] ? '0 : CUM_W'(old3);
        REQ_AVERAGE: val = cum3;
        REQ_UNKNOWN: val = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_rg <= regret_in;
      s2    <= sat;
      old2  <= old_reg;
      cum2  <= old_cum;
      prod3 <= prod;
      old3  <= old2;
      cum3  <= cum2;
      cdsh3 <= cd[47:16];
      val4  <= val;
      newr4 <= newr;
      cdsh4 <= cdsh3;
    end
  end

endmodule

[rtl/drmu_sum.sv]
module drmu_sum
  import drmu_pkg::*;
#(
  parameter int LANES = 8
) (
  input  logic             clk,
  input  logic             adv,
  input  logic [CUM_W-1:0] val [LANES],
  output logic [SUM_W-1:0] sum
);

  localparam int NP = (LANES + 1) / 2;

  logic [CUM_W:0]   pair_d [NP];
  logic [CUM_W:0]   pair_q [NP];
  logic [SUM_W-1:0] total;

  always_comb begin
    for (int i = 0; i < NP; i++) begin
      if (2 * i + 1 < LANES) begin
        pair_d[i] = {1'b0, val[2*i]} + {1'b0, val[2*i+1]};
      end else begin
        pair_d[i] = {1'b0, val[2*i]};
      end
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < NP; i++) begin
      total = total + SUM_W'(pair_q[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pair_q <= pair_d;
      sum    <= total;
    end
  end

endmodule

[rtl/drmu_lane_back.sv]
module drmu_lane_back
  import drmu_pkg::*;
(
  input  logic                       clk,
  input  logic                       adv,
  input  logic [CUM_W-1:0]           val4,
  input  logic signed [REGRET_W-1:0] newr4,
  input  logic [CUM_W-1:0]           cdsh4,
  input  logic [SUM_W-1:0]           sum6,
  input  req_t                       req_fin,
  input  logic                       lane_on,
  input  logic [PROB_W-1:0]          uniform,
  input  logic [WEIGHT_W-1:0]        avg_w,
  output logic [PROB_W-1:0]          prob_out,
  output logic signed [REGRET_W-1:0] newr_out,
  output logic [CUM_W-1:0]           cavg_out
);

  logic [CUM_W-1:0]           val5, val6, cs5, cs6;
  logic signed [REGRET_W-1:0] nr5, nr6;

  logic [REM_W-1:0]           rem [1:DIV_STEPS];
  logic [PROB_W-1:0]          quo [1:DIV_STEPS];
  logic [SUM_W-1:0]           sm  [1:DIV_STEPS];
  logic signed [REGRET_W-1:0] nr  [1:DIV_STEPS];
  logic [CUM_W-1:0]           cs  [1:DIV_STEPS];

  logic [PROB_W-1:0]          p1, p2, prob;
  logic signed [REGRET_W-1:0] nrf1, nrf2;
  logic [CUM_W-1:0]           csf1, csf2;
  logic [32:0]                pa;
  logic [CUM_W:0]             c;

  always_ff @(posedge clk) begin
    if (adv) begin
      val5 <= val4;
      nr5  <= newr4;
      cs5  <= cdsh4;
      val6 <= val5;
      nr6  <= nr5;
      cs6  <= cs5;
    end
  end

  // restoring divider, one quotient bit per stage: first the integer bit,
  // then sixteen fraction bits
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [REM_W-1:0]           r_in, t;
    logic [PROB_W-1:0]          q_in;
    logic [SUM_W-1:0]           s_in;
    logic signed [REGRET_W-1:0] n_in;
    logic [CUM_W-1:0]           c_in;
    logic                       ge;

    if (k == 0) begin : g_first
      assign r_in = REM_W'(val6);
      assign q_in = '0;
      assign s_in = sum6;
      assign n_in = nr6;
      assign c_in = cs6;
      assign t    = r_in;
    end else begin : g_next
      assign r_in = rem[k];
      assign q_in = quo[k];
      assign s_in = sm[k];
      assign n_in = nr[k];
      assign c_in = cs[k];
      assign t    = {r_in[REM_W-2:0], 1'b0};
    end

    assign ge = (t >= REM_W'(s_in));

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k+1] <= ge ? t - REM_W'(s_in) : t;
        quo[k+1] <= {q_in[PROB_W-2:0], ge};
        sm[k+1]  <= s_in;
        nr[k+1]  <= n_in;
        cs[k+1]  <= c_in;
      end
    end
  end

  always_comb begin
    if (req_fin == REQ_UNKNOWN || !lane_on) begin
      prob = '0;
    end else if (sm[DIV_STEPS] == '0) begin
      prob = uniform;
    end else begin
      prob = quo[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1   <= prob;
      nrf1 <= nr[DIV_STEPS];
      csf1 <= cs[DIV_STEPS];
      p2   <= p1;
      pa   <= 33'(p1) * 33'(avg_w);
      nrf2 <= nrf1;
      csf2 <= csf1;
    end
  end

  always_comb begin
    c        = {1'b0, csf2} + (CUM_W + 1)'(pa[32:16]);
    cavg_out = c[CUM_W] ? '1 : c[CUM_W-1:0];
  end

  assign prob_out = p2;
  assign newr_out = nrf2;

endmodule

[tb/sv/discounted_regret_matching_update_core_test.sv]
`timescale 1ns / 100ps

module discounted_regret_matching_update_core_test;
  import drmu_pkg::*;

  localparam int HANDS = 2048;
  localparam int LANES = 8;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [HAND_W-1:0] hand;
    logic [LANES-1:0][PROB_W-1:0] prob;
  } strat_t;

  typedef struct {
    req_t kind;
    logic [HAND_W-1:0] hand;
    logic signed [REGRET_W-1:0] regret [LANES];
    logic has_fixed;
    strat_t fixed;
  } req_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WEIGHT_W-1:0] cfg_data = '0;

  drmu_req_if req ();
  drmu_rsp_if rsp ();

  discounted_regret_matching_update_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req.sink), .rsp(rsp.source)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [COUNT_W-1:0] m_count;
  logic [WEIGHT_W-1:0] m_pos_w, m_neg_w, m_avg_w, m_decay;
  logic signed [REGRET_W-1:0] m_regret [HANDS*LANES];
  logic [CUM_W-1:0] m_cum [HANDS*LANES];

  strat_t strat_q [$];
  int errors = 0;
  int cycles = 0;
  bit hold_rsp = 0;
  bit long_stall = 0;
  event hold_go;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic int unsigned lanes_in_use();
    if (m_count == 0) return 1;
    if (m_count > LANES) return LANES;
    return m_count;
  endfunction

  function automatic void match_probs(input logic [63:0] v [LANES], input int unsigned n,
                                      output logic [LANES-1:0][PROB_W-1:0] p);
    logic [63:0] s;
    s = 0;
    p = '0;
    for (int a = 0; a < n; a++) s += v[a];
    for (int a = 0; a < n; a++)
      p[a] = (s == 0) ? PROB_W'(65536 / n) : PROB_W'((v[a] << 16) / s);
  endfunction

  function automatic strat_t predict_strategy(input req_row_t r);
    strat_t o;
    int unsigned n, base;
    logic [63:0] v [LANES];
    longint s, prod;
    logic [63:0] c;
    n = lanes_in_use();
    base = (r.hand % HANDS) * LANES;
    o.hand = r.hand;
    o.prob = '0;
    for (int a = 0; a < LANES; a++) v[a] = 0;
    if (r.kind == REQ_UPDATE) begin
      for (int a = 0; a < n; a++) begin
        s = longint'(m_regret[base+a]) + longint'(r.regret[a]);
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        prod = s * longint'(s > 0 ? m_pos_w : m_neg_w);
        m_regret[base+a] = REGRET_W'(prod >>> 16);
      end
    end
    if (r.kind == REQ_UPDATE || r.kind == REQ_CURRENT) begin
      for (int a = 0; a < n; a++) v[a] = (m_regret[base+a] > 0) ? m_regret[base+a] : 0;
      match_probs(v, n, o.prob);
    end else if (r.kind == REQ_AVERAGE) begin
      for (int a = 0; a < n; a++) v[a] = m_cum[base+a];
      match_probs(v, n, o.prob);
    end
    if (r.kind == REQ_UPDATE) begin
      for (int a = 0; a < n; a++) begin
        c = (64'(m_cum[base+a]) * m_decay) >> 16;
        c += (64'(o.prob[a]) * m_avg_w) >> 16;
        m_cum[base+a] = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
      end
    end
    return o;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[WEIGHT_W-1:0];
    case (idx)
      CFG_ACTION_COUNT: m_count = val[COUNT_W-1:0];
      CFG_POSITIVE_WEIGHT: m_pos_w = val[15:0];
      CFG_NEGATIVE_WEIGHT: m_neg_w = val[15:0];
      CFG_AVERAGE_WEIGHT: m_avg_w = val[15:0];
      default: m_decay = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (strat_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic send(input req_row_t r);
    strat_t e;
    e = predict_strategy(r);
    if (r.has_fixed) e = r.fixed;
    strat_q = {strat_q, e};
    req.valid <= 1'b1;
    req.req_type <= r.kind;
    req.hand <= r.hand;
    req.regret_a0 <= r.regret[0]; req.regret_a1 <= r.regret[1];
    req.regret_a2 <= r.regret[2]; req.regret_a3 <= r.regret[3];
    req.regret_a4 <= r.regret[4]; req.regret_a5 <= r.regret[5];
    req.regret_a6 <= r.regret[6]; req.regret_a7 <= r.regret[7];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic idle_gap(input int n);
    req.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_regret();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom;
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return 32'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  function automatic req_row_t make_row(input req_t k, input int h, input logic [31:0] fill);
    req_row_t r;
    r.kind = k;
    r.hand = h;
    for (int a = 0; a < LANES; a++) r.regret[a] = fill;
    r.has_fixed = 0;
    r.fixed = '0;
    return r;
  endfunction

  // receiver: random stalls plus a long hold-off when asked
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) rsp.ready <= 1'b0;
    else if (hold_rsp) rsp.ready <= 1'b0;
    else if (long_stall) rsp.ready <= ($urandom_range(0, 3) == 0);
    else rsp.ready <= ($urandom_range(0, 4) != 0);
  end

  // long hold-off, timed in cycles here
  initial begin
    @(hold_go);
    hold_rsp = 1;
    repeat (300) @(posedge clk);
    hold_rsp = 0;
  end

  always @(posedge clk) begin
    strat_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (strat_q.size() == 0) begin
        report("unexpected beat hand", rsp.hand_out, -1);
      end else begin
        e = strat_q.pop_front();
        if (rsp.hand_out !== e.hand) report("hand_out", rsp.hand_out, e.hand);
        if (rsp.prob_a0 !== e.prob[0]) report("prob_a0", rsp.prob_a0, e.prob[0]);
        if (rsp.prob_a1 !== e.prob[1]) report("prob_a1", rsp.prob_a1, e.prob[1]);
        if (rsp.prob_a2 !== e.prob[2]) report("prob_a2", rsp.prob_a2, e.prob[2]);
        if (rsp.prob_a3 !== e.prob[3]) report("prob_a3", rsp.prob_a3, e.prob[3]);
        if (rsp.prob_a4 !== e.prob[4]) report("prob_a4", rsp.prob_a4, e.prob[4]);
        if (rsp.prob_a5 !== e.prob[5]) report("prob_a5", rsp.prob_a5, e.prob[5]);
        if (rsp.prob_a6 !== e.prob[6]) report("prob_a6", rsp.prob_a6, e.prob[6]);
        if (rsp.prob_a7 !== e.prob[7]) report("prob_a7", rsp.prob_a7, e.prob[7]);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("discounted_regret_matching_update_core_test: FAIL");
      $finish;
    end
  end

  initial begin
    req_row_t table_rows [$];
    req_row_t r;
    int burst, hot;
    int unsigned cfgv [5];
    bit stalled;
    stalled = 0;
    req.valid = 1'b0;
    req.req_type = REQ_UPDATE;
    req.hand = '0;
    {req.regret_a0, req.regret_a1, req.regret_a2, req.regret_a3} = '0;
    {req.regret_a4, req.regret_a5, req.regret_a6, req.regret_a7} = '0;
    m_count = 2; m_pos_w = 32768; m_neg_w = 32768; m_avg_w = 32768; m_decay = 65535;
    for (int i = 0; i < HANDS * LANES; i++) begin
      m_regret[i] = 0;
      m_cum[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: fixed results after reset and for the unknown request
    r = make_row(REQ_CURRENT, 5, 0);
    r.has_fixed = 1; r.fixed.hand = 5; r.fixed.prob[0] = 32768; r.fixed.prob[1] = 32768;
    table_rows = {table_rows, r};
    r = make_row(REQ_AVERAGE, 2047, 0);
    r.has_fixed = 1; r.fixed.hand = 2047; r.fixed.prob[0] = 32768; r.fixed.prob[1] = 32768;
    table_rows = {table_rows, r};
    r = make_row(REQ_UNKNOWN, 9, 32'h7FFF_FFFF);
    r.has_fixed = 1; r.fixed.hand = 9;
    table_rows = {table_rows, r};
    table_rows = {table_rows, make_row(REQ_UPDATE, 0, 32'h7FFF_FFFF)};
    table_rows = {table_rows, make_row(REQ_UPDATE, 0, 32'h7FFF_FFFF)};  // sum saturates
    table_rows = {table_rows, make_row(REQ_UPDATE, 1, 32'h8000_0000)};
    table_rows = {table_rows, make_row(REQ_UPDATE, 1, 32'h8000_0000)};
    table_rows = {table_rows, make_row(REQ_CURRENT, 1, 0)};  // all negative: uniform
    table_rows = {table_rows, make_row(REQ_AVERAGE, 0, 0)};
    r = make_row(REQ_UPDATE, 3, 32'h0001_0000); r.regret[1] = 32'hFFFF_0000;
    table_rows = {table_rows, r};
    table_rows = {table_rows, make_row(REQ_UPDATE, 3, 32'h0000_0001)};
    table_rows = {table_rows, make_row(REQ_AVERAGE, 3, 0)};
    table_rows = {table_rows, make_row(REQ_CURRENT, 2047, 0)};
    r = make_row(REQ_UPDATE, 2047, 32'h5555_5555); r.regret[1] = 32'hAAAA_AAAA;
    table_rows = {table_rows, r};
    foreach (table_rows[i]) send(table_rows[i]);
    idle_gap(1);
    drain();

    // extreme and random settings, each followed by random traffic
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: cfgv = '{8, 65535, 65535, 65535, 65535};
        1: cfgv = '{1, 0, 0, 0, 0};
        2: cfgv = '{0, 65535, 0, 65535, 0};
        3: cfgv = '{15, 1, 65535, 1, 65535};
        default: cfgv = '{$urandom_range(0, 15), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535)};
      endcase
      write_reg(CFG_ACTION_COUNT, cfgv[0]);
      write_reg(CFG_POSITIVE_WEIGHT, cfgv[1]);
      write_reg(CFG_NEGATIVE_WEIGHT, cfgv[2]);
      write_reg(CFG_AVERAGE_WEIGHT, cfgv[3]);
      write_reg(CFG_AVERAGE_DECAY, cfgv[4]);
      hot = $urandom_range(0, 2047);
      for (int i = 0; i < 190; ) begin
        if (phase == 5 && i >= 60 && !stalled) begin
          stalled = 1;
          long_stall = 1;
          -> hold_go;
        end
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && i < 190; b++, i++) begin
          r.kind = req_t'($urandom_range(0, 9) < 6 ? REQ_UPDATE :
                          $urandom_range(1, 3));
          // mostly a handful of hot rows so state builds up
          r.hand = ($urandom_range(0, 3) != 0) ? 11'(hot + $urandom_range(0, 3))
                                                 : 11'($urandom);
          for (int a = 0; a < LANES; a++) r.regret[a] = rand_regret();
          r.has_fixed = 0;
          send(r);
        end
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 30));
      end
      idle_gap(1);
      long_stall = 0;
      drain();
    end

    if (errors == 0) begin
      $display("discounted_regret_matching_update_core_test: PASS");
    end else begin
      $display("discounted_regret_matching_update_core_test: FAIL");
    end
    $finish;
  end

endmodule

[discounted_regret_matching_update_core.f]
+incdir+rtl
rtl/drmu_pkg.sv
rtl/drmu_if.sv
rtl/drmu_ram.sv
rtl/drmu_lane_front.sv
rtl/drmu_sum.sv
rtl/drmu_lane_back.sv
rtl/discounted_regret_matching_update_core.sv
tb/sv/discounted_regret_matching_update_core_test.sv
